### sv/gdo_pkg.sv
// ----------------------------------------------------------------------------
// gdo_pkg: shared types and constants for the gregorian date offset unit
// sequencer states, datapath micro-op command, calendar constants and tables
// ----------------------------------------------------------------------------
`default_nettype none

package gdo_pkg;

  // default year window
  localparam int MIN_YEAR_DEF = 1582;
  localparam int MAX_YEAR_DEF = 9999;

  // days in the gregorian cycles
  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_1Y   = 365;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D100_EST,
    ST_D100_BACK,
    ST_D100_FIX,
    ST_FWD_MUL,
    ST_FWD_ADD1,
    ST_FWD_ADD2,
    ST_FWD_ADD3,
    ST_CLAMP,
    ST_WK_EST,
    ST_WK_BACK,
    ST_WK_FIX,
    ST_WK_SAVE,
    ST_C400_EST,
    ST_C400_BACK,
    ST_C400_FIX,
    ST_C100_EST,
    ST_C100_BACK,
    ST_C100_FIX,
    ST_C4_EST,
    ST_C4_BACK,
    ST_C4_FIX,
    ST_C1_EST,
    ST_C1_BACK,
    ST_C1_FIX,
    ST_YMUL,
    ST_YADD,
    ST_MONTH,
    ST_FINISH
  } state_t;

  // datapath micro-ops
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EST,
    OP_BACK,
    OP_FIX,
    OP_FWD_MUL,
    OP_FWD_ADD1,
    OP_FWD_ADD2,
    OP_FWD_ADD3,
    OP_CLAMP,
    OP_SERIAL_M1,
    OP_YMUL,
    OP_YADD,
    OP_MONTH,
    OP_OUT
  } op_t;

  // constant divisor of the shared divide step
  typedef enum logic [2:0] {
    DSEL_100,
    DSEL_7,
    DSEL_400Y,
    DSEL_100Y,
    DSEL_4Y,
    DSEL_1Y
  } dsel_t;

  // where the last quotient or remainder is parked
  typedef enum logic [2:0] {
    SAVE_NONE,
    SAVE_Q100,
    SAVE_WDAY,
    SAVE_Q400,
    SAVE_C,
    SAVE_Q4,
    SAVE_Y1
  } save_t;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_EARLY = 2'd1,
    CLAMP_LATE  = 2'd2
  } clamp_t;

  // command from sequencer to datapath
  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    save_t save;
  } cmd_t;

  // days before january 1 of year y, elaboration use only
  function automatic longint days_before_year(input longint y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  // days before the first of month m (1..12) in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### sv/gdo_ctrl.sv
// ----------------------------------------------------------------------------
// gdo_ctrl: sequencer for the gregorian date offset unit
// steps the datapath through one conversion and owns both handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module gdo_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output gdo_pkg::cmd_t      cmd
);
  import gdo_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    cmd           = '{op: OP_NONE, dsel: DSEL_100, save: SAVE_NONE};
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_D100_EST;
        end
      end
      // year - 1 divided by 100
      ST_D100_EST: begin
        cmd.op    = OP_EST;
        state_nxt = ST_D100_BACK;
      end
      ST_D100_BACK: begin
        cmd.op    = OP_BACK;
        state_nxt = ST_D100_FIX;
      end
      ST_D100_FIX: begin
        cmd.op    = OP_FIX;
        state_nxt = ST_FWD_MUL;
      end
      // date to serial count plus offset
      ST_FWD_MUL: begin
        cmd.op    = OP_FWD_MUL;
        cmd.save  = SAVE_Q100;
        state_nxt = ST_FWD_ADD1;
      end
      ST_FWD_ADD1: begin
        cmd.op    = OP_FWD_ADD1;
        state_nxt = ST_FWD_ADD2;
      end
      ST_FWD_ADD2: begin
        cmd.op    = OP_FWD_ADD2;
        state_nxt = ST_FWD_ADD3;
      end
      ST_FWD_ADD3: begin
        cmd.op    = OP_FWD_ADD3;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = ST_WK_EST;
      end
      // weekday
      ST_WK_EST: begin
        cmd.op    = OP_EST;
        cmd.dsel  = DSEL_7;
        state_nxt = ST_WK_BACK;
      end
      ST_WK_BACK: begin
        cmd.op    = OP_BACK;
        cmd.dsel  = DSEL_7;
        state_nxt = ST_WK_FIX;
      end
      ST_WK_FIX: begin
        cmd.op    = OP_FIX;
        cmd.dsel  = DSEL_7;
        state_nxt = ST_WK_SAVE;
      end
      ST_WK_SAVE: begin
        cmd.op    = OP_SERIAL_M1;
        cmd.save  = SAVE_WDAY;
        state_nxt = ST_C400_EST;
      end
      // serial count to year through the cycle lengths
      ST_C400_EST: begin
        cmd.op    = OP_EST;
        cmd.dsel  = DSEL_400Y;
        state_nxt = ST_C400_BACK;
      end
      ST_C400_BACK: begin
        cmd.op    = OP_BACK;
        cmd.dsel  = DSEL_400Y;
        state_nxt = ST_C400_FIX;
      end
      ST_C400_FIX: begin
        cmd.op    = OP_FIX;
        cmd.dsel  = DSEL_400Y;
        state_nxt = ST_C100_EST;
      end
      ST_C100_EST: begin
        cmd.op    = OP_EST;
        cmd.dsel  = DSEL_100Y;
        cmd.save  = SAVE_Q400;
        state_nxt = ST_C100_BACK;
      end
      ST_C100_BACK: begin
        cmd.op    = OP_BACK;
        cmd.dsel  = DSEL_100Y;
        state_nxt = ST_C100_FIX;
      end
      ST_C100_FIX: begin
        cmd.op    = OP_FIX;
        cmd.dsel  = DSEL_100Y;
        state_nxt = ST_C4_EST;
      end
      ST_C4_EST: begin
        cmd.op    = OP_EST;
        cmd.dsel  = DSEL_4Y;
        cmd.save  = SAVE_C;
        state_nxt = ST_C4_BACK;
      end
      ST_C4_BACK: begin
        cmd.op    = OP_BACK;
        cmd.dsel  = DSEL_4Y;
        state_nxt = ST_C4_FIX;
      end
      ST_C4_FIX: begin
        cmd.op    = OP_FIX;
        cmd.dsel  = DSEL_4Y;
        state_nxt = ST_C1_EST;
      end
      ST_C1_EST: begin
        cmd.op    = OP_EST;
        cmd.dsel  = DSEL_1Y;
        cmd.save  = SAVE_Q4;
        state_nxt = ST_C1_BACK;
      end
      ST_C1_BACK: begin
        cmd.op    = OP_BACK;
        cmd.dsel  = DSEL_1Y;
        state_nxt = ST_C1_FIX;
      end
      ST_C1_FIX: begin
        cmd.op    = OP_FIX;
        cmd.dsel  = DSEL_1Y;
        state_nxt = ST_YMUL;
      end
      ST_YMUL: begin
        cmd.op    = OP_YMUL;
        cmd.save  = SAVE_Y1;
        state_nxt = ST_YADD;
      end
      ST_YADD: begin
        cmd.op    = OP_YADD;
        state_nxt = ST_MONTH;
      end
      ST_MONTH: begin
        cmd.op    = OP_MONTH;
        state_nxt = ST_FINISH;
      end
      // hand over once the output register is free
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

### sv/gdo_dp.sv
// ----------------------------------------------------------------------------
// gdo_dp: datapath of the gregorian date offset unit
// one shared multiplier, divide by constant via reciprocal and one correction
// ----------------------------------------------------------------------------
`default_nettype none

module gdo_dp #(
  parameter int MIN_YEAR = gdo_pkg::MIN_YEAR_DEF,
  parameter int MAX_YEAR = gdo_pkg::MAX_YEAR_DEF
) (
  input  wire logic               clk,
  input  wire gdo_pkg::cmd_t      cmd,
  input  wire logic [13:0]        in_year,
  input  wire logic [3:0]         in_month,
  input  wire logic [4:0]         in_day,
  input  wire logic signed [20:0] offset_days,
  output logic [13:0]             out_year,
  output logic [3:0]              out_month,
  output logic [4:0]              out_day,
  output logic [21:0]             serial_day,
  output logic [2:0]              weekday,
  output logic [8:0]              day_in_year,
  output logic                    leap_flag,
  output logic [1:0]              clamp_code
);
  import gdo_pkg::*;

  localparam int     YW     = $clog2(MAX_YEAR + 1);
  localparam longint HI_DAY = days_before_year(longint'(MAX_YEAR) + 1);
  localparam longint LO_DAY = days_before_year(longint'(MIN_YEAR)) + 1;
  localparam int     SW     = $clog2(HI_DAY + 1);
  localparam int     AW     = SW + 2;
  localparam longint SPAN   = longint'(1) << SW;

  localparam logic [SW-1:0] LO_S     = SW'(LO_DAY);
  localparam logic [SW-1:0] HI_S     = SW'(HI_DAY);
  localparam logic [SW-1:0] RCP_100  = SW'(SPAN / 100);
  localparam logic [SW-1:0] RCP_7    = SW'(SPAN / 7);
  localparam logic [SW-1:0] RCP_400Y = SW'(SPAN / DAYS_400Y);
  localparam logic [SW-1:0] RCP_100Y = SW'(SPAN / DAYS_100Y);
  localparam logic [SW-1:0] RCP_4Y   = SW'(SPAN / DAYS_4Y);
  localparam logic [SW-1:0] RCP_1Y   = SW'(SPAN / DAYS_1Y);

  // working registers
  logic [YW-1:0]        p_r;
  logic [3:0]           month_r;
  logic [4:0]           day_r;
  logic signed [20:0]   off_r;
  logic [SW-1:0]        x_r;
  logic [SW-1:0]        q_r;
  logic [2*SW-1:0]      prod_r;
  logic signed [AW-1:0] acc_r;
  logic [SW-1:0]        s_r;
  clamp_t               clamp_r;
  logic [YW-1:0]        q100_r;
  logic                 leap_in_r;
  logic [2:0]           wday_r;
  logic [YW-1:0]        q400_r;
  logic [1:0]           c_r;
  logic [4:0]           q4_r;
  logic [1:0]           y1_r;
  logic [8:0]           doy_r;
  logic [YW-1:0]        oy_r;
  logic                 leap_out_r;
  logic [3:0]           om_r;
  logic [4:0]           od_r;

  // output register
  logic [13:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [21:0] serial_r;
  logic [2:0]  weekday_r;
  logic [8:0]  doy_out_r;
  logic        leap_r;
  logic [1:0]  clamp_out_r;

  // divisor and reciprocal
  logic [SW-1:0] div_d;
  logic [SW-1:0] div_m;
  logic          div_sat;

  always_comb begin
    div_sat = 1'b0;
    case (cmd.dsel)
      DSEL_100: begin
        div_d = SW'(100);
        div_m = RCP_100;
      end
      DSEL_7: begin
        div_d = SW'(7);
        div_m = RCP_7;
      end
      DSEL_400Y: begin
        div_d = SW'(DAYS_400Y);
        div_m = RCP_400Y;
      end
      DSEL_100Y: begin
        div_d   = SW'(DAYS_100Y);
        div_m   = RCP_100Y;
        div_sat = 1'b1;
      end
      DSEL_4Y: begin
        div_d = SW'(DAYS_4Y);
        div_m = RCP_4Y;
      end
      DSEL_1Y: begin
        div_d   = SW'(DAYS_1Y);
        div_m   = RCP_1Y;
        div_sat = 1'b1;
      end
      default: begin
        div_d = SW'(100);
        div_m = RCP_100;
      end
    endcase
  end

  // shared multiplier
  logic [SW-1:0]   mul_a;
  logic [SW-1:0]   mul_b;
  logic [2*SW-1:0] mul_p;

  always_comb begin
    case (cmd.op)
      OP_BACK: begin
        mul_a = prod_r[2*SW-1:SW];
        mul_b = div_d;
      end
      OP_FWD_MUL: begin
        mul_a = SW'(p_r);
        mul_b = SW'(DAYS_1Y);
      end
      OP_YMUL: begin
        mul_a = SW'(q400_r);
        mul_b = SW'(400);
      end
      default: begin
        mul_a = x_r;
        mul_b = div_m;
      end
    endcase
  end

  assign mul_p = (2*SW)'(mul_a) * (2*SW)'(mul_b);

  // remainder and one-step correction, quotient estimate is exact or one low
  logic [SW-1:0] fix_r;
  logic [SW-1:0] fix_rd;
  logic [SW-1:0] fix_q_nxt;
  logic [SW-1:0] fix_rem_nxt;

  always_comb begin
    fix_r  = x_r - prod_r[SW-1:0];
    fix_rd = fix_r - div_d;
    if (fix_r >= div_d) begin
      fix_q_nxt   = q_r + SW'(1);
      fix_rem_nxt = fix_rd;
    end else begin
      fix_q_nxt   = q_r;
      fix_rem_nxt = fix_r;
    end
    // last day of a 400 or 4 year cycle stays in the final century or year
    if (div_sat && fix_q_nxt == SW'(4)) begin
      fix_q_nxt   = SW'(3);
      fix_rem_nxt = div_d;
    end
  end

  // input clamping
  logic [16:0] yc;
  logic [3:0]  mc;

  always_comb begin
    yc = 17'(in_year);
    if (yc < 17'(MIN_YEAR)) begin
      yc = 17'(MIN_YEAR);
    end else if (yc > 17'(MAX_YEAR)) begin
      yc = 17'(MAX_YEAR);
    end
    mc = in_month;
    if (mc < 4'd1) begin
      mc = 4'd1;
    end else if (mc > 4'd12) begin
      mc = 4'd12;
    end
  end

  // day offset within the starting year
  logic [9:0] fwd_md;
  assign fwd_md = 10'(cum_days(month_r)) + 10'((month_r > 4'd2) && leap_in_r) + 10'(day_r);

  // clamp of the shifted serial count
  logic [SW-1:0] s_nxt;
  clamp_t        clamp_nxt;

  always_comb begin
    if (acc_r < $signed(AW'(LO_S))) begin
      s_nxt     = LO_S;
      clamp_nxt = CLAMP_EARLY;
    end else if (acc_r > $signed(AW'(HI_S))) begin
      s_nxt     = HI_S;
      clamp_nxt = CLAMP_LATE;
    end else begin
      s_nxt     = acc_r[SW-1:0];
      clamp_nxt = CLAMP_NONE;
    end
  end

  // month search over the cumulative table
  logic [3:0] om_nxt;
  logic [8:0] mbase;

  always_comb begin
    logic [8:0] dbm;
    om_nxt = 4'd1;
    mbase  = 9'd0;
    for (int m = 2; m <= 12; m++) begin
      dbm = cum_days(4'(m)) + 9'((m > 2) && leap_out_r);
      if (dbm < doy_r) begin
        om_nxt = 4'(m);
        mbase  = dbm;
      end
    end
  end

  logic [8:0] od_full;
  assign od_full = doy_r - mbase;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        p_r     <= YW'(yc - 17'd1);
        x_r     <= SW'(yc - 17'd1);
        month_r <= mc;
        day_r   <= in_day;
        off_r   <= offset_days;
      end
      OP_EST: begin
        prod_r <= mul_p;
      end
      OP_BACK: begin
        q_r    <= prod_r[2*SW-1:SW];
        prod_r <= mul_p;
      end
      OP_FIX: begin
        q_r <= fix_q_nxt;
        x_r <= fix_rem_nxt;
      end
      OP_FWD_MUL: begin
        prod_r <= mul_p;
      end
      OP_FWD_ADD1: begin
        acc_r <= $signed(AW'(prod_r[SW-1:0])) + $signed(AW'(p_r >> 2))
                 - $signed(AW'(q100_r));
      end
      OP_FWD_ADD2: begin
        acc_r <= acc_r + $signed(AW'(q100_r >> 2)) + $signed(AW'(fwd_md));
      end
      OP_FWD_ADD3: begin
        acc_r <= acc_r + AW'(off_r);
      end
      OP_CLAMP: begin
        s_r     <= s_nxt;
        clamp_r <= clamp_nxt;
        x_r     <= s_nxt;
      end
      OP_SERIAL_M1: begin
        x_r <= s_r - SW'(1);
      end
      OP_YMUL: begin
        prod_r <= mul_p;
      end
      OP_YADD: begin
        oy_r <= prod_r[YW-1:0] + YW'(c_r) * YW'(100) + YW'({q4_r, 2'b00})
                + YW'(y1_r) + YW'(1);
        leap_out_r <= (y1_r == 2'd3) && ((q4_r != 5'd24) || (c_r == 2'd3));
      end
      OP_MONTH: begin
        om_r <= om_nxt;
        od_r <= od_full[4:0];
      end
      OP_OUT: begin
        out_year_r  <= 14'(oy_r);
        out_month_r <= om_r;
        out_day_r   <= od_r;
        serial_r    <= 22'(s_r);
        weekday_r   <= wday_r;
        doy_out_r   <= doy_r;
        leap_r      <= leap_out_r;
        clamp_out_r <= clamp_r;
      end
      default: begin
      end
    endcase

    case (cmd.save)
      SAVE_Q100: begin
        q100_r <= YW'(q_r);
        // leap if year divisible by 4, and by 400 when divisible by 100
        leap_in_r <= (p_r[1:0] == 2'd3) && ((x_r != SW'(99)) || (q_r[1:0] == 2'd3));
      end
      SAVE_WDAY: begin
        wday_r <= x_r[2:0];
      end
      SAVE_Q400: begin
        q400_r <= YW'(q_r);
      end
      SAVE_C: begin
        c_r <= q_r[1:0];
      end
      SAVE_Q4: begin
        q4_r <= q_r[4:0];
      end
      SAVE_Y1: begin
        y1_r  <= q_r[1:0];
        doy_r <= x_r[8:0] + 9'd1;
      end
      default: begin
      end
    endcase
  end

  assign out_year    = out_year_r;
  assign out_month   = out_month_r;
  assign out_day     = out_day_r;
  assign serial_day  = serial_r;
  assign weekday     = weekday_r;
  assign day_in_year = doy_out_r;
  assign leap_flag   = leap_r;
  assign clamp_code  = clamp_out_r;

endmodule

`default_nettype wire

### sv/gregorian_date_offset_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_offset_unit: shifts a gregorian date by a signed day count
// returns the new date, its serial day number, weekday, ordinal day, leap
// flag and a clamp code
//
// usage:
//  - in_* is a stream slave, one transaction carries year, month, day and a
//    signed offset; out_* is a stream master, one result transaction per input
//  - an input is taken only while the sequencer is idle; the result shows on
//    out_tvalid after the sequence of 28 steps, and the next input is not
//    taken until the sequencer is back in idle
//  - the steps all go through one shared multiplier: a divide by a constant
//    costs three steps (reciprocal estimate, back multiply, remainder
//    correction) and is done six times
//  - results sit in an output register, so the next input is accepted and
//    worked on while a result still waits; a stalled receiver holds the
//    block in its last step until the output register is free
//  - reset clears the sequencer and the output valid flag; there are no
//    stored tables to clear
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_offset_unit #(
  parameter int MIN_YEAR = gdo_pkg::MIN_YEAR_DEF,
  parameter int MAX_YEAR = gdo_pkg::MAX_YEAR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transaction
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_year[13:0], in_month[17:14], in_day[22:18], offset_days[43:23],
  // zero pad [47:44]
  input  wire logic [47:0] in_tdata,
  // result transaction
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_year[13:0], out_month[17:14], out_day[22:18], serial_day[44:23],
  // weekday[47:45], day_in_year[56:48], leap_flag[57], clamp_code[59:58],
  // zero pad [63:60]
  output logic [63:0]      out_tdata
);
  import gdo_pkg::*;

  cmd_t cmd;

  // result fields from the datapath output register
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [21:0] serial_day;
  logic [2:0]  weekday;
  logic [8:0]  day_in_year;
  logic        leap_flag;
  logic [1:0]  clamp_code;

  // sequencer: handshakes and step order
  gdo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // datapath: clamping, conversions, shared multiplier
  gdo_dp #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .in_year     (in_tdata[13:0]),
    .in_month    (in_tdata[17:14]),
    .in_day      (in_tdata[22:18]),
    .offset_days ($signed(in_tdata[43:23])),
    .out_year    (out_year),
    .out_month   (out_month),
    .out_day     (out_day),
    .serial_day  (serial_day),
    .weekday     (weekday),
    .day_in_year (day_in_year),
    .leap_flag   (leap_flag),
    .clamp_code  (clamp_code)
  );

  assign out_tdata = {4'b0000, clamp_code, leap_flag, day_in_year, weekday,
                      serial_day, out_day, out_month, out_year};

endmodule

`default_nettype wire

### verif/gregorian_date_offset_unit_tb.sv
// ----------------------------------------------------------------------------
// gregorian_date_offset_unit_tb: self-checking bench for the date offset unit
// drives dates and day offsets over the input stream, predicts each shifted
// date, serial count, weekday, ordinal day, leap flag and clamp code, and
// compares every result transaction in order; both sides stall at random
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_offset_unit_tb;
  import gdo_pkg::*;

  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int  IDLE_PCT     = 11;
  localparam int  YEAR_LO      = MIN_YEAR_DEF;
  localparam int  YEAR_HI      = MAX_YEAR_DEF;
  localparam int  MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                       304, 334};

  // result fields, msb first so that out_tdata[59:0] casts straight in
  typedef struct packed {
    clamp_t      clamp;
    logic        leap;
    logic [8:0]  yday;
    logic [2:0]  wday;
    logic [21:0] serial;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  date_result_t pending_dates [$];
  int           mismatch_cnt = 0;
  int           cycle_cnt    = 0;
  bit           idle_on      = 1'b1;
  int           hold_req     = 0;
  int           hold_done    = 0;
  int           hold_left    = 0;

  gregorian_date_offset_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // calendar prediction
  // --------------------------------------------------------------------------
  function automatic bit leap_year(input longint y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic longint days_to_jan1(input longint y);
    longint p;
    p = y - 1;
    return p * DAYS_1Y + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint days_to_month(input longint y, input longint m);
    longint d;
    d = MONTH_START[m - 1];
    if (m > 2 && leap_year(y))
      d = d + 1;
    return d;
  endfunction

  function automatic date_result_t shift_date(input logic [13:0] y_in,
                                              input logic [3:0] m_in,
                                              input logic [4:0] d_in,
                                              input logic signed [20:0] off_in);
    longint       y, m, d, off, s, lo, hi, n, r, q400, c, q4, y1, oy, doy, om;
    date_result_t res;
    y   = y_in;
    m   = m_in;
    d   = d_in;
    off = off_in;
    res.clamp = CLAMP_NONE;
    // out-of-range year and month are pinned before the offset is added
    if (y < YEAR_LO) y = YEAR_LO;
    if (y > YEAR_HI) y = YEAR_HI;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    // day counts as plain days, so day 0 and overlong days roll naturally
    s  = days_to_jan1(y) + days_to_month(y, m) + d + off;
    lo = days_to_jan1(YEAR_LO) + 1;
    hi = days_to_jan1(YEAR_HI + 1);
    if (s < lo) begin
      s = lo;
      res.clamp = CLAMP_EARLY;
    end else if (s > hi) begin
      s = hi;
      res.clamp = CLAMP_LATE;
    end
    // back to a date through the 400, 100, 4 and 1 year cycles
    n    = s - 1;
    q400 = n / DAYS_400Y;
    r    = n % DAYS_400Y;
    c    = r / DAYS_100Y;
    if (c == 4) c = 3;
    r    = r - c * DAYS_100Y;
    q4   = r / DAYS_4Y;
    r    = r % DAYS_4Y;
    y1   = r / DAYS_1Y;
    if (y1 == 4) y1 = 3;
    r    = r - y1 * DAYS_1Y;
    oy   = q400 * 400 + c * 100 + q4 * 4 + y1 + 1;
    doy  = r + 1;
    om   = 12;
    while (om > 1 && days_to_month(oy, om) >= doy)
      om = om - 1;
    res.year   = oy[13:0];
    res.month  = om[3:0];
    res.day    = 5'(doy - days_to_month(oy, om));
    res.serial = s[21:0];
    res.wday   = 3'(s % 7);
    res.yday   = doy[8:0];
    res.leap   = leap_year(oy);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // expectation store and result check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : date_check
    date_result_t got, want;
    if (rst_n && in_tvalid && in_tready)
      pending_dates.push_back(shift_date(in_tdata[13:0], in_tdata[17:14],
                                         in_tdata[22:18], in_tdata[43:23]));
    if (rst_n && out_tvalid && out_tready) begin
      got = date_result_t'(out_tdata[59:0]);
      if (pending_dates.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result transaction: %0d-%0d-%0d serial %0d",
                   got.year, got.month, got.day, got.serial);
      end else begin
        want = pending_dates.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
            got.serial !== want.serial || got.wday !== want.wday ||
            got.yday !== want.yday || got.leap !== want.leap ||
            got.clamp !== want.clamp) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch exp: %0d-%0d-%0d serial %0d wday %0d yday %0d leap %0d clamp %0d",
                     want.year, want.month, want.day, want.serial, want.wday,
                     want.yday, want.leap, want.clamp);
            $display("         got: %0d-%0d-%0d serial %0d wday %0d yday %0d leap %0d clamp %0d",
                     got.year, got.month, got.day, got.serial, got.wday,
                     got.yday, got.leap, got.clamp);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= hold_done + 1;
    end else if (!idle_on) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sender: valid stays high from one transaction to the next unless a gap
  // is inserted, so it is never lowered and raised in the same step
  // --------------------------------------------------------------------------
  task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic [20:0] off);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, off, d, m, y};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_date();
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [20:0] off;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // raw bits over the whole field ranges
      y   = 14'($urandom());
      m   = 4'($urandom());
      d   = 5'($urandom());
      off = 21'($urandom());
    end else begin
      if (pick < 40)
        y = 14'($urandom_range(YEAR_LO + 8, YEAR_LO));
      else if (pick < 50)
        y = 14'($urandom_range(YEAR_HI, YEAR_HI - 8));
      else
        y = 14'($urandom_range(YEAR_HI, YEAR_LO));
      m = 4'($urandom_range(12, 1));
      d = ($urandom_range(99) < 80) ? 5'($urandom_range(28, 1)) : 5'($urandom_range(31, 29));
      pick = $urandom_range(99);
      if (pick < 40)
        off = 21'(int'($urandom_range(800)) - 400);
      else if (pick < 75)
        off = 21'(int'($urandom_range(80000)) - 40000);
      else
        off = 21'($urandom());
    end
    send_date(y, m, d, off);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_field_extremes();
    send_date(14'd2024, 4'd1, 5'd1, 21'd0);           // plain query
    send_date(14'd0, 4'd0, 5'd0, 21'd0);              // all fields zero
    send_date(14'd1581, 4'd6, 5'd15, 21'd0);          // year below window
    send_date(14'h3FFF, 4'hF, 5'h1F, 21'd0);          // all fields ones
    send_date(14'd10000, 4'd13, 5'd1, 21'h1FFFFF);    // year above window, month 13
    send_date(14'd2000, 4'd1, 5'd1, 21'h0FFFFF);      // largest forward offset
    send_date(14'd2000, 4'd1, 5'd1, 21'h100000);      // largest backward offset
    send_date(14'd9999, 4'd1, 5'd1, 21'h0FFFFF);
  endtask

  task automatic test_window_clamps();
    send_date(14'd1582, 4'd1, 5'd1, 21'h1FFFFF);      // one day too early
    send_date(14'd1582, 4'd1, 5'd1, 21'd0);           // earliest date itself
    send_date(14'd9999, 4'd12, 5'd31, 21'd0);         // latest date itself
    send_date(14'd9999, 4'd12, 5'd31, 21'd1);         // one day too late
  endtask

  task automatic test_month_ends();
    send_date(14'd2000, 4'd2, 5'd29, 21'd0);          // leap day, 400 year rule
    send_date(14'd1900, 4'd2, 5'd29, 21'd0);          // century non-leap rolls to march
    send_date(14'd2400, 4'd2, 5'd28, 21'd1);
    send_date(14'd2000, 4'd3, 5'd0, 21'd0);           // day zero in a leap year
    send_date(14'd2023, 4'd3, 5'd0, 21'd0);           // day zero in a common year
    send_date(14'd2023, 4'd12, 5'd31, 21'd1);         // year rollover
    send_date(14'd2024, 4'd12, 5'd31, 21'd0);         // ordinal day 366
    send_date(14'd2000, 4'd12, 5'd31, -21'sd366);
    send_date(14'd1600, 4'd2, 5'd29, -21'sd1);
    send_date(14'd5000, 4'd7, 5'd31, -21'sd1);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    bit saved;
    saved     = idle_on;
    idle_on   = 1'b0;
    hold_req  = hold_req + 1;
    repeat (20) send_random_date();
    idle_on   = saved;
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (300) send_random_date();
    idle_on = 1'b1;
  endtask

  task automatic test_random_dates();
    repeat (1560) send_random_date();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_window_clamps();
    test_month_ends();
    test_backpressure();
    test_steady_stream();
    test_random_dates();
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_dates.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
sv/gdo_pkg.sv
sv/gdo_ctrl.sv
sv/gdo_dp.sv
sv/gregorian_date_offset_unit.sv
verif/gregorian_date_offset_unit_tb.sv
